>>> design/doubly_linked_list_position_ops_macros.svh
// Assertion helpers shared by the list sequencer and its allocator.
// Both expect i_clk and an active-low i_rst_n in the using module.
`ifndef DOUBLY_LINKED_LIST_POSITION_OPS_MACROS_SVH
`define DOUBLY_LINKED_LIST_POSITION_OPS_MACROS_SVH

// Same-cycle implication
`define DLLPO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DLLPO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dllpo_pkg.sv
`default_nettype none

package dllpo_pkg;

    // Pool geometry
    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LINK_W      = $clog2(CAPACITY + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

    // Command codes
    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_POS  = 3'd5
    } t_opcode;

    // Result codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LINK_NEW,
        S_FIX_NEXT,
        S_FIX_PREV
    } t_state;

    // One link memory entry
    typedef struct packed {
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } t_link;

    // Node memory access request
    typedef struct packed {
        logic                   rd_en;
        logic [IDX_W-1:0]       rd_addr;
        logic                   val_rd_en;
        logic [IDX_W-1:0]       val_rd_addr;
        logic                   wr_nxt_en;
        logic                   wr_prv_en;
        logic                   wr_val_en;
        logic [IDX_W-1:0]       wr_addr;
        t_link                  wr_link;
        logic [VALUE_WIDTH-1:0] wr_val;
    } t_mem_req;

    // Free map update
    typedef struct packed {
        logic             take;
        logic [IDX_W-1:0] take_idx;
        logic             give;
        logic [IDX_W-1:0] give_idx;
    } t_alloc_cmd;

    // Input word to stored word: sign-extend, keep the low bits
    function automatic logic [VALUE_WIDTH-1:0] to_word(input logic [31:0] v);
        logic [63:0] e;
        e = {{32{v[31]}}, v};
        return e[VALUE_WIDTH-1:0];
    endfunction

    // Stored word to result field: sign-extend, truncate to 32 bits
    function automatic logic [31:0] from_word(input logic [VALUE_WIDTH-1:0] w);
        logic [63:0] e;
        e = 64'(signed'(w));
        return e[31:0];
    endfunction

    // Lowest set bit of the free map
    function automatic logic [IDX_W-1:0] lowest_free(input logic [CAPACITY-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (m[i]) idx = IDX_W'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> design/dllpo_mem.sv
`default_nettype none

module dllpo_mem
    import dllpo_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire t_mem_req               i_req,
    output t_link                       o_link_rd,
    output logic [VALUE_WIDTH-1:0]      o_value_rd
);

    t_link                  r_link_mem  [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_value_mem [CAPACITY];
    t_link                  r_link_rd;
    logic [VALUE_WIDTH-1:0] r_value_rd;

    // Link memory: one read, one write with per-field enables
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) r_link_rd <= r_link_mem[i_req.rd_addr];
        if (i_req.wr_nxt_en) r_link_mem[i_req.wr_addr].nxt <= i_req.wr_link.nxt;
        if (i_req.wr_prv_en) r_link_mem[i_req.wr_addr].prv <= i_req.wr_link.prv;
    end

    // Value memory: one read, one write
    always_ff @(posedge i_clk) begin
        if (i_req.val_rd_en) r_value_rd <= r_value_mem[i_req.val_rd_addr];
        if (i_req.wr_val_en) r_value_mem[i_req.wr_addr] <= i_req.wr_val;
    end

    assign o_link_rd  = r_link_rd;
    assign o_value_rd = r_value_rd;

endmodule

`default_nettype wire

>>> design/dllpo_alloc.sv
`default_nettype none

`include "doubly_linked_list_position_ops_macros.svh"

module dllpo_alloc
    import dllpo_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_alloc_cmd       i_cmd,
    output logic [IDX_W-1:0]      o_idx,
    output logic                  o_full
);

    logic [CAPACITY-1:0] r_free_map;
    logic [CAPACITY-1:0] n_free_map;

    // Claim and release of pool slots
    always_comb begin
        n_free_map = r_free_map;
        if (i_cmd.take) n_free_map[i_cmd.take_idx] = 1'b0;
        if (i_cmd.give) n_free_map[i_cmd.give_idx] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map <= '1;
        end else begin
            r_free_map <= n_free_map;
        end
    end

    assign o_idx  = lowest_free(r_free_map);
    assign o_full = ~|r_free_map;

    `DLLPO_ASSERT_NOW(a_take_free, i_cmd.take, r_free_map[i_cmd.take_idx], "claimed slot not free")
    `DLLPO_ASSERT_NOW(a_give_used, i_cmd.give, !r_free_map[i_cmd.give_idx], "released slot free")
    `DLLPO_ASSERT_NOW(a_one_op, i_cmd.take, !i_cmd.give, "claim and release together")

endmodule

`default_nettype wire

>>> design/doubly_linked_list_position_ops.sv
// Channel   | Signals                                  | Handshake
// ----------+------------------------------------------+------------------------------
// command   | i_opcode, i_value, i_position            | taken when start && !busy
// result    | o_status, o_result_value                 | o_valid for one cycle
//
// After the accept cycle a walk visits one node per cycle (up to CAPACITY) on the
// link read port; an insert then writes in S_LINK_NEW, S_FIX_NEXT, S_FIX_PREV, a
// delete in S_FIX_NEXT, S_FIX_PREV. Errors found at accept answer next cycle.
// The result strobe follows the last update cycle; busy drops at the same time.
// Synchronous active-low reset empties the list and frees every slot at once.
// Results cannot be stalled; each one is valid for exactly one cycle.
`default_nettype none

`include "doubly_linked_list_position_ops_macros.svh"

module doubly_linked_list_position_ops
    import dllpo_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_opcode,
    input  wire logic signed [31:0] i_value,
    input  wire logic [7:0]         i_position,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_result_value
);

    t_state                  r_state, n_state;
    logic [VALUE_WIDTH-1:0]  r_value, n_value;
    logic [7:0]              r_left, n_left;
    logic                    r_tail_mode, n_tail_mode;
    logic                    r_is_ins, n_is_ins;
    logic [IDX_W-1:0]        r_new, n_new;
    logic [LINK_W-1:0]       r_cur, n_cur;
    logic [LINK_W-1:0]       r_nn, n_nn;     // new node: next
    logic [LINK_W-1:0]       r_np, n_np;     // new node: prev
    logic [LINK_W-1:0]       r_pn, n_pn;     // node whose next is fixed (NIL: head)
    logic [LINK_W-1:0]       r_pv, n_pv;
    logic [LINK_W-1:0]       r_fn, n_fn;     // node whose prev is fixed (NIL: none)
    logic [LINK_W-1:0]       r_fv, n_fv;
    logic [LINK_W-1:0]       r_head, n_head;
    logic                    r_valid, n_valid;
    t_status                 r_status, n_status;
    logic [31:0]             r_result, n_result;

    t_mem_req                mem_req;
    t_link                   link_rd;
    logic [VALUE_WIDTH-1:0]  value_rd;
    t_alloc_cmd              alloc_cmd;
    logic [IDX_W-1:0]        free_idx;
    logic                    pool_full;
    logic                    list_empty;
    logic                    found;

    dllpo_mem u_mem (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_link_rd  (link_rd),
        .o_value_rd (value_rd)
    );

    dllpo_alloc u_alloc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alloc_cmd),
        .o_idx   (free_idx),
        .o_full  (pool_full)
    );

    assign list_empty = (r_head == NIL);
    assign found      = r_tail_mode ? (link_rd.nxt == NIL) : (r_left == 8'd0);

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL;
            r_valid  <= 1'b0;
            r_status <= STAT_OK;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    // Transaction payload and walk registers
    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_left      <= n_left;
        r_tail_mode <= n_tail_mode;
        r_is_ins    <= n_is_ins;
        r_new       <= n_new;
        r_cur       <= n_cur;
        r_nn        <= n_nn;
        r_np        <= n_np;
        r_pn        <= n_pn;
        r_pv        <= n_pv;
        r_fn        <= n_fn;
        r_fv        <= n_fv;
    end

    // Sequencer: decode, walk, relink
    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_left      = r_left;
        n_tail_mode = r_tail_mode;
        n_is_ins    = r_is_ins;
        n_new       = r_new;
        n_cur       = r_cur;
        n_nn        = r_nn;
        n_np        = r_np;
        n_pn        = r_pn;
        n_pv        = r_pv;
        n_fn        = r_fn;
        n_fv        = r_fv;
        n_head      = r_head;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_result    = r_result;
        mem_req     = '0;
        alloc_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_value = to_word(i_value);
                    n_new   = free_idx;
                    unique case (i_opcode) inside
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                            n_is_ins = 1'b1;
                            if (pool_full) begin
                                n_valid  = 1'b1;
                                n_status = STAT_FULL;
                                n_result = '0;
                            end else if (i_opcode == OP_INS_HEAD || list_empty ||
                                         (i_opcode == OP_INS_POS && i_position == 8'd1)) begin
                                // new node becomes the head
                                n_nn    = r_head;
                                n_np    = NIL;
                                n_pn    = NIL;
                                n_pv    = LINK_W'(free_idx);
                                n_fn    = r_head;
                                n_fv    = LINK_W'(free_idx);
                                n_state = S_LINK_NEW;
                            end else begin
                                n_tail_mode     = (i_opcode == OP_INS_TAIL);
                                n_left          = (i_position <= 8'd2) ? 8'd0
                                                                       : i_position - 8'd2;
                                n_cur           = r_head;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = r_head[IDX_W-1:0];
                                n_state         = S_WALK;
                            end
                        end
                        OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                            n_is_ins = 1'b0;
                            if (list_empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                                n_result = '0;
                            end else if (i_opcode == OP_DEL_POS && i_position == 8'd0) begin
                                n_valid  = 1'b1;
                                n_status = STAT_RANGE;
                                n_result = '0;
                            end else begin
                                n_tail_mode     = (i_opcode == OP_DEL_TAIL);
                                n_left          = (i_opcode == OP_DEL_POS) ? i_position - 8'd1
                                                                           : 8'd0;
                                n_cur           = r_head;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = r_head[IDX_W-1:0];
                                n_state         = S_WALK;
                            end
                        end
                        default: begin
                            // unused opcodes: no change
                            n_valid  = 1'b1;
                            n_status = STAT_OK;
                            n_result = '0;
                        end
                    endcase
                end
            end

            S_WALK: begin
                if (found) begin
                    if (r_is_ins) begin
                        // link after the found node
                        n_nn    = link_rd.nxt;
                        n_np    = r_cur;
                        n_pn    = r_cur;
                        n_pv    = LINK_W'(r_new);
                        n_fn    = link_rd.nxt;
                        n_fv    = LINK_W'(r_new);
                        n_state = S_LINK_NEW;
                    end else begin
                        // unlink the found node, fetch its value
                        n_pn                = link_rd.prv;
                        n_pv                = link_rd.nxt;
                        n_fn                = link_rd.nxt;
                        n_fv                = link_rd.prv;
                        mem_req.val_rd_en   = 1'b1;
                        mem_req.val_rd_addr = r_cur[IDX_W-1:0];
                        n_state             = S_FIX_NEXT;
                    end
                end else if (link_rd.nxt == NIL) begin
                    n_valid  = 1'b1;
                    n_status = STAT_RANGE;
                    n_result = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_cur           = link_rd.nxt;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = link_rd.nxt[IDX_W-1:0];
                    if (!r_tail_mode) n_left = r_left - 8'd1;
                end
            end

            S_LINK_NEW: begin
                mem_req.wr_nxt_en   = 1'b1;
                mem_req.wr_prv_en   = 1'b1;
                mem_req.wr_val_en   = 1'b1;
                mem_req.wr_addr     = r_new;
                mem_req.wr_link.nxt = r_nn;
                mem_req.wr_link.prv = r_np;
                mem_req.wr_val      = r_value;
                alloc_cmd.take      = 1'b1;
                alloc_cmd.take_idx  = r_new;
                n_state             = S_FIX_NEXT;
            end

            S_FIX_NEXT: begin
                if (r_pn == NIL) begin
                    n_head = r_pv;
                end else begin
                    mem_req.wr_nxt_en   = 1'b1;
                    mem_req.wr_addr     = r_pn[IDX_W-1:0];
                    mem_req.wr_link.nxt = r_pv;
                end
                n_state = S_FIX_PREV;
            end

            S_FIX_PREV: begin
                if (r_fn != NIL) begin
                    mem_req.wr_prv_en   = 1'b1;
                    mem_req.wr_addr     = r_fn[IDX_W-1:0];
                    mem_req.wr_link.prv = r_fv;
                end
                if (!r_is_ins) begin
                    alloc_cmd.give     = 1'b1;
                    alloc_cmd.give_idx = r_cur[IDX_W-1:0];
                end
                n_valid  = 1'b1;
                n_status = STAT_OK;
                n_result = r_is_ins ? from_word(r_value) : from_word(value_rd);
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_result_value = r_result;

    `DLLPO_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result while busy")
    `DLLPO_ASSERT_NOW(a_walk_live, r_state == S_WALK, r_cur != NIL, "walk on null link")
    `DLLPO_ASSERT_NOW(a_err_zero, o_valid && o_status != STAT_OK, o_result_value == 32'd0,
                      "nonzero value on error")
    `DLLPO_ASSERT_NEXT(a_full_rej, start && !busy && pool_full && i_opcode == OP_INS_HEAD,
                       o_valid && o_status == STAT_FULL, "full pool not reported")

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench
    import dllpo_pkg::*;
();

    // Opcodes the block answers with ok and a zero word, touching nothing
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int ITEM_COUNT   = 450;
    localparam int QUIET_TAIL   = 60;    // last commands go back to back
    localparam int PHASE_LEN    = 60;    // commands per grow/shrink/mixed phase
    localparam int DRAIN_AT     = 200;   // command count where the sender waits for all results
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        t_status     st;
        logic [31:0] word;
    } t_list_answer;

    // Tracks the list contents in order and the answers still to come
    class list_scoreboard;
        logic [VALUE_WIDTH-1:0] chain[$];
        t_list_answer           awaited[$];
        int                     status_seen[4];
        int                     longest;

        // Stored word back to the 32-bit result field, sign-extended
        function logic [31:0] widen(input logic [VALUE_WIDTH-1:0] w);
            logic signed [63:0] wide;
            wide = 64'(w) << (64 - VALUE_WIDTH);
            wide = wide >>> (64 - VALUE_WIDTH);
            return wide[31:0];
        endfunction

        // Apply one accepted command to the list and queue its answer
        function void note_command(input logic [2:0] op, input logic [31:0] value,
                                   input logic [7:0] pos);
            logic signed [63:0]     wide;
            logic [VALUE_WIDTH-1:0] w;
            t_list_answer           ans;
            int                     at;
            wide     = signed'(value);
            w        = wide[VALUE_WIDTH-1:0];
            ans.st   = STAT_OK;
            ans.word = '0;
            case (op)
                OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                    // pool full wins over any position check
                    if (chain.size() >= CAPACITY) begin
                        ans.st = STAT_FULL;
                    end else begin
                        // empty list takes any position; 0 and 2 land behind the head
                        if (chain.size() == 0 || op == OP_INS_HEAD) at = 0;
                        else if (op == OP_INS_TAIL) at = chain.size();
                        else if (pos == 8'd1) at = 0;
                        else if (pos == 8'd0) at = 1;
                        else at = int'(pos) - 1;
                        if (at > chain.size()) begin
                            ans.st = STAT_RANGE;
                        end else begin
                            chain.insert(at, w);
                            ans.word = widen(w);
                        end
                    end
                end
                OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                    if (chain.size() == 0) begin
                        ans.st = STAT_EMPTY;
                    end else begin
                        if (op == OP_DEL_HEAD) at = 0;
                        else if (op == OP_DEL_TAIL) at = chain.size() - 1;
                        else at = int'(pos) - 1;
                        if (at < 0 || at >= chain.size()) begin
                            ans.st = STAT_RANGE;
                        end else begin
                            ans.word = widen(chain[at]);
                            chain.delete(at);
                        end
                    end
                end
                default: ;
            endcase
            awaited.push_back(ans);
            if (chain.size() > longest) longest = chain.size();
        endfunction

        // Compare one result against the oldest answer; nonzero on mismatch
        function int check_result(input logic [1:0] st, input logic [31:0] word,
                                  output string why);
            t_list_answer ans;
            why = "";
            if (awaited.size() == 0) begin
                why = $sformatf("unexpected result status %0d word %h", st, word);
                return 1;
            end
            ans = awaited.pop_front();
            status_seen[ans.st]++;
            if (st !== ans.st)
                why = $sformatf("status %0d, want %s", st, ans.st.name());
            if (word !== ans.word)
                why = {why, $sformatf(" word %h, want %h", word, ans.word)};
            return (why != "") ? 1 : 0;
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic [2:0]         i_opcode   = '0;
    logic signed [31:0] i_value    = '0;
    logic [7:0]         i_position = '0;
    logic               busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_result_value;

    list_scoreboard book;
    int             fail_count   = 0;
    int             issued       = 0;
    int             quiet_cycles = 0;

    doubly_linked_list_position_ops dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_value (o_result_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at %0t:%s", $time, what);
    endtask

    // Present one command and hold it until the block takes it
    task automatic issue(input logic [2:0] op, input logic [31:0] value,
                         input logic [7:0] pos);
        start      <= 1'b1;
        i_opcode   <= op;
        i_value    <= value;
        i_position <= pos;
        do @(posedge i_clk); while (busy);
        book.note_command(op, value, pos);
        if (op <= OP_DEL_POS) issued++;
    endtask

    // Sender gap; payload wiggles while start is low
    task automatic pause(input int cycles);
        start      <= 1'b0;
        i_opcode   <= 3'($urandom_range(0, 7));
        i_value    <= $urandom();
        i_position <= 8'($urandom_range(0, 255));
        repeat (cycles) @(posedge i_clk);
    endtask

    // Result checking
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_valid) begin
            if (book.check_result(o_status, o_result_value, why) != 0) report_mismatch(why);
        end
    end

    // Watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("stalled %0d cycles, %0d results outstanding",
                     STALL_LIMIT, book.awaited.size());
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          len, roll, grow_pct, phase;
        bit          drained;
        logic [2:0]  op;
        logic [7:0]  pos;
        logic [31:0] value;
        book    = new();
        drained = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, extreme words and positions, every opcode
        issue(OP_DEL_HEAD, 32'h0000_0000, 8'd0);
        issue(OP_DEL_TAIL, 32'hFFFF_FFFF, 8'hFF);
        issue(OP_DEL_POS,  32'h0000_0000, 8'd1);
        issue(OP_INS_POS,  32'h7FFF_FFFF, 8'd200);
        issue(OP_INS_HEAD, 32'h8000_0000, 8'd0);
        issue(OP_INS_TAIL, 32'h0000_0000, 8'hFF);
        issue(OP_INS_POS,  32'hFFFF_FFFF, 8'd1);
        issue(OP_INS_POS,  32'h0000_0001, 8'd0);
        issue(OP_INS_POS,  32'h5555_5555, 8'd2);
        issue(OP_INS_POS,  32'hAAAA_AAAA, 8'd7);
        issue(OP_INS_POS,  32'h1234_5678, 8'd9);
        issue(OP_INS_POS,  32'h0F0F_0F0F, 8'hFF);
        issue(OP_SPARE_6,  32'hDEAD_BEEF, 8'd3);
        issue(OP_SPARE_7,  32'h0000_0000, 8'hFF);
        issue(OP_DEL_POS,  32'h0000_0000, 8'd0);
        issue(OP_DEL_POS,  32'h0000_0000, 8'hFF);
        issue(OP_DEL_POS,  32'h0000_0000, 8'd8);
        issue(OP_DEL_POS,  32'h0000_0000, 8'd7);
        issue(OP_DEL_POS,  32'h0000_0000, 8'd3);
        issue(OP_DEL_POS,  32'h0000_0000, 8'd1);
        issue(OP_DEL_TAIL, 32'h0000_0000, 8'd0);
        issue(OP_DEL_HEAD, 32'h0000_0000, 8'd0);

        // Random: phases that fill the pool, drain it, then churn
        while (issued < ITEM_COUNT) begin
            if (issued >= DRAIN_AT && !drained) begin
                drained = 1'b1;
                start <= 1'b0;
                do @(posedge i_clk); while (book.awaited.size() != 0);
            end else if (issued < ITEM_COUNT - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                pause($urandom_range(1, 13));
            end
            len   = book.chain.size();
            phase = (issued / PHASE_LEN) % 3;
            grow_pct = (phase == 0) ? 80 : (phase == 1) ? 20 : 50;
            roll  = $urandom_range(0, 99);
            if (roll < 2) op = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
            else if ($urandom_range(0, 99) < grow_pct) op = 3'($urandom_range(0, 2));
            else op = 3'($urandom_range(3, 5));

            roll = $urandom_range(0, 9);
            if (roll == 0) value = 32'h8000_0000;
            else if (roll == 1) value = 32'h7FFF_FFFF;
            else if (roll == 2) value = 32'hFFFF_FFFF;
            else value = $urandom();

            // positions mostly near the list length, sometimes anywhere
            roll = $urandom_range(0, 9);
            if (roll < 7)
                pos = (op == OP_INS_POS) ? 8'($urandom_range(0, len + 2))
                                         : 8'($urandom_range(1, len + 1));
            else if (roll == 7) pos = 8'd0;
            else pos = 8'($urandom_range(0, 255));
            issue(op, value, pos);
        end

        start <= 1'b0;
        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d list commands run; ok %0d, empty %0d, out of range %0d, full %0d",
                 issued, book.status_seen[STAT_OK], book.status_seen[STAT_EMPTY],
                 book.status_seen[STAT_RANGE], book.status_seen[STAT_FULL]);
        $display("longest list %0d of %0d nodes; %0d mismatches",
                 book.longest, CAPACITY, fail_count);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/dllpo_pkg.sv
design/dllpo_mem.sv
design/dllpo_alloc.sv
design/doubly_linked_list_position_ops.sv
verif/testbench.sv
